/* sv/sbe_pkg.sv */
`timescale 1ns / 1ps

package sbe_pkg;

  // Field widths of the transactions and of the stored sensor id
  localparam int BYTE_W   = 8;
  localparam int PLACE_W  = 4;
  localparam int NUM_W    = 5;
  localparam int ID_W     = PLACE_W + NUM_W;
  localparam int LETTER_W = 3;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 16;
  localparam int SEL_W    = 3;

  // Sensor number of bit 7 in an even and in an odd byte of the poll
  localparam logic [NUM_W-1:0] LOW_BASE  = 5'd1;
  localparam logic [NUM_W-1:0] HIGH_BASE = 5'd9;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One scan step: candidate sensor and whether it is an event
  typedef struct packed {
    logic               emit;
    logic               last;
    logic [PLACE_W-1:0] place;
    logic [NUM_W-1:0]   num;
  } scan_event_t;

  // Ring view seen by the scanner and the output stage
  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] total;
    logic [ID_W-1:0]    last_id;
  } ring_status_t;

endpackage

/* sv/sbe_in_if.sv */
`timescale 1ns / 1ps

interface sbe_in_if;
  import sbe_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sensor_byte;
  logic              first_of_poll;

  modport source (output valid, output sensor_byte, output first_of_poll, input ready);
  modport sink (input valid, input sensor_byte, input first_of_poll, output ready);

endinterface

/* sv/sbe_out_if.sv */
`timescale 1ns / 1ps

interface sbe_out_if;
  import sbe_pkg::*;

  logic                valid;
  logic                ready;
  logic [LETTER_W-1:0] module_letter;
  logic [NUM_W-1:0]    sensor_number;
  logic [SLOT_W-1:0]   ring_slot;
  logic [COUNT_W-1:0]  events_total;
  logic                last_of_run;

  modport source (output valid, output module_letter, output sensor_number,
                  output ring_slot, output events_total, output last_of_run,
                  input ready);
  modport sink (input valid, input module_letter, input sensor_number,
                input ring_slot, input events_total, input last_of_run,
                output ready);

endinterface

/* sv/sensor_bank_event_extractor_top.sv */
`timescale 1ns / 1ps

// Channel     Modport        Transaction
// sensor_in   sbe_in_if      sink    one status byte and its first-of-poll flag
// event_out   sbe_out_if     source  one sensor event
//
// A byte is scanned one set bit at a time; a zero byte is not scanned. The
// scanner clears one bit of its mask register per cycle while the output is free.
// The ring memory takes one write per event and one read per cycle.
// Reset (rst, synchronous) clears the place, pointer, count and last sensor.
// A stalled output register holds the scan; the next byte is taken in the
// cycle in which the last bit of the current one is scanned.

module sensor_bank_event_extractor_top #(
  parameter int POLL_BYTES   = 10,
  parameter int RECENT_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  sbe_in_if.sink      sensor_in,
  sbe_out_if.source   event_out
);
  import sbe_pkg::*;

  scan_event_t   ev;
  ring_status_t  ring_st;
  logic          out_free;
  logic          scan_busy;
  logic          ring_wr;
  logic [ID_W-1:0] ring_wr_id;

  logic                ov;
  logic [LETTER_W-1:0] letter_q;
  logic [NUM_W-1:0]    num_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [COUNT_W-1:0]  total_q;
  logic                last_q;

  assign out_free   = !ov || event_out.ready;
  assign ring_wr    = ev.emit;
  assign ring_wr_id = {ev.place, ev.num};

  sbe_scan #(
    .POLL_BYTES (POLL_BYTES)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sensor_in.valid),
    .in_byte  (sensor_in.sensor_byte),
    .in_first (sensor_in.first_of_poll),
    .in_ready (sensor_in.ready),
    .out_free (out_free),
    .last_id  (ring_st.last_id),
    .ev       (ev),
    .busy     (scan_busy)
  );

  sbe_ring #(
    .RECENT_DEPTH (RECENT_DEPTH)
  ) u_ring (
    .clk   (clk),
    .rst   (rst),
    .wr_en (ring_wr),
    .wr_id (ring_wr_id),
    .st    (ring_st)
  );

  // Load the output register on an event, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ev.emit) begin
      ov <= 1'b1;
    end else if (event_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev.emit) begin
      letter_q <= ev.place[PLACE_W-1:1];
      num_q    <= ev.num;
      slot_q   <= ring_st.slot;
      total_q  <= ring_st.total;
      last_q   <= ev.last;
    end
  end

  assign event_out.valid         = ov;
  assign event_out.module_letter = letter_q;
  assign event_out.sensor_number = num_q;
  assign event_out.ring_slot     = slot_q;
  assign event_out.events_total  = total_q;
  assign event_out.last_of_run   = last_q;

  // The newest id is visible to the scanner in the cycle after its write
  a_forward: assert property (@(posedge clk) disable iff (rst)
    ring_wr |=> (ring_st.last_id == $past(ring_wr_id)))
    else $error("last sensor id not forwarded after ring write");

  // A stalled output freezes the scan
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (scan_busy && !out_free) |=> (scan_busy && $stable(ev.place) && $stable(ev.num)))
    else $error("scan moved while output stalled");

  // An event names a sensor of a byte within the poll
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    event_out.valid |-> (event_out.sensor_number != '0 &&
                         event_out.sensor_number <= 5'd16 &&
                         {2'b00, event_out.module_letter, 1'b0} < 6'(POLL_BYTES)))
    else $error("event outside the sensor range");

endmodule

/* sv/sbe_scan.sv */
`timescale 1ns / 1ps

module sbe_scan #(
  parameter int POLL_BYTES = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [sbe_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_first,
  output logic                       in_ready,
  input  logic                       out_free,
  input  logic [sbe_pkg::ID_W-1:0]   last_id,
  output sbe_pkg::scan_event_t       ev,
  output logic                       busy
);
  import sbe_pkg::*;

  localparam logic [PLACE_W:0] POLL_LIM = (PLACE_W + 1)'(POLL_BYTES);

  logic [BYTE_W-1:0]  mask;
  logic [PLACE_W-1:0] place_q;
  logic [PLACE_W-1:0] pos_q;

  logic [SEL_W-1:0]   sel;
  logic               found;
  logic [BYTE_W-1:0]  mask_clr;
  logic [NUM_W-1:0]   num;
  logic [ID_W-1:0]    id;
  logic               step;
  logic               accept;
  logic [PLACE_W-1:0] place_in;
  logic [PLACE_W:0]   place_inc;
  logic [PLACE_W-1:0] pos_next;

  // Pick the highest remaining set bit: bit 7 is the lowest sensor
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = 0; k < BYTE_W; k++) begin
      if (!found && mask[BYTE_W-1-k]) begin
        sel   = SEL_W'(k);
        found = 1'b1;
      end
    end
  end

  assign mask_clr = mask & ~(BYTE_W'(8'h80) >> sel);
  assign num      = (place_q[0] ? HIGH_BASE : LOW_BASE) + NUM_W'(sel);
  assign id       = {place_q, num};

  // Advance one bit per cycle while the output slot is free
  assign step     = busy && out_free;
  assign ev.emit  = step && (id != last_id);
  assign ev.last  = (mask_clr == '0);
  assign ev.place = place_q;
  assign ev.num   = num;

  // Take the next byte when idle or when the current one finishes now
  assign in_ready = !busy || (step && (mask_clr == '0));
  assign accept   = in_valid && in_ready;

  // Place of the incoming byte within its poll
  always_comb begin
    if (in_first || ({1'b0, pos_q} >= POLL_LIM)) begin
      place_in = '0;
    end else begin
      place_in = pos_q;
    end
    place_inc = {1'b0, place_in} + 1'b1;
    if (place_inc >= POLL_LIM) begin
      pos_next = '0;
    end else begin
      pos_next = place_inc[PLACE_W-1:0];
    end
  end

  // Load a byte or clear the bit just scanned
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pos_q <= '0;
      mask  <= '0;
    end else if (accept) begin
      pos_q   <= pos_next;
      busy    <= (in_byte != '0);
      mask    <= in_byte;
      place_q <= place_in;
    end else if (step) begin
      mask <= mask_clr;
      if (mask_clr == '0) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

/* sv/sbe_ring.sv */
`timescale 1ns / 1ps

module sbe_ring #(
  parameter int RECENT_DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [sbe_pkg::ID_W-1:0] wr_id,
  output sbe_pkg::ring_status_t    st
);
  import sbe_pkg::*;

  localparam int PTR_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RECENT_DEPTH - 1);

  logic [ID_W-1:0]    mem [RECENT_DEPTH];
  logic [ID_W-1:0]    rd_q;
  logic [ID_W-1:0]    fwd_id_q;
  logic               fwd_q;
  logic               has_q;
  logic [PTR_W-1:0]   ptr_q;
  logic [COUNT_W-1:0] count_q;

  logic [PTR_W-1:0]   last_slot;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   ptr_next;
  logic [COUNT_W-1:0] count_next;

  assign last_slot  = (ptr_q == '0) ? PTR_LAST : ptr_q - 1'b1;
  assign ptr_next   = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
  assign count_next = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 1'b1;

  // Read the slot that holds the newest id after this cycle
  assign rd_addr = wr_en ? ptr_q : last_slot;

  // Write the event id and read back the newest entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ptr_q] <= wr_id;
    end
    rd_q     <= mem[rd_addr];
    fwd_id_q <= wr_id;
  end

  // Advance the pointer and the saturating count on each event
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr_q   <= '0;
      count_q <= '0;
      has_q   <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      fwd_q <= wr_en;
      if (wr_en) begin
        ptr_q   <= ptr_next;
        count_q <= count_next;
        has_q   <= 1'b1;
      end
    end
  end

  // Forward a write of the last cycle over the stale read
  assign st.last_id = !has_q ? '0 : (fwd_q ? fwd_id_q : rd_q);
  assign st.slot    = SLOT_W'(ptr_q);
  assign st.total   = count_next;

endmodule
